@@ design/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam logic [2:0] K_START  = 3'd0;
  localparam logic [2:0] K_SHORT  = 3'd1;
  localparam logic [2:0] K_LONG   = 3'd2;
  localparam logic [2:0] K_VLONG  = 3'd3;
  localparam logic [2:0] K_DOUBLE = 3'd4;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_LONG   = 2'd1;
  localparam logic [1:0] REG_VLONG  = 2'd2;
  localparam logic [1:0] REG_MASKS  = 2'd3;

  // per-button entry of the state memory
  typedef struct packed {
    logic        active;
    logic [31:0] start;
    logic [2:0]  cls;
    logic        win_open;
    logic [31:0] win_start;
    logic [9:0]  level;
  } btn_state_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DIV, ST_WRITE, ST_OUT
  } fsm_e;

  // divider request toward the iterative unit
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

endpackage

@@ design/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// Radix-4 restoring divider, unsigned 48 by 32 bits.
// ----------------------------------------------------------------------------
module bpc_div
  import bpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [47:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] r1, r2;
  logic [34:0] t1, t2;
  logic        q1, q2;

  always_comb begin
    r1 = {rem_q[32:0], quo_q[47]};
    t1 = {1'b0, r1} - {3'b0, den_q};
    q1 = !t1[34];
    if (q1) r1 = t1[33:0];
    r2 = {r1[32:0], quo_q[46]};
    t2 = {1'b0, r2} - {3'b0, den_q};
    q2 = !t2[34];
    if (q2) r2 = t2[33:0];
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = r2;
      quo_d = {quo_q[45:0], q1, q2};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) den_q <= req_i.den;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ design/button_press_classifier.sv @@
// ----------------------------------------------------------------------------
// button_press_classifier
// Grades button polls as press start, short, long, very long or double press.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one poll beat: button index, level, timestamp, held time.
//   m_axis returns exactly one result beat per poll: event flag, button,
//   release flag, event kind, Q2.8 hold progress and the sticky redraw flag.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no poll is in flight.
// Timing:
//   The result beat is offered once the poll beat has passed through one
//   memory read, the radix-4 divider (24 steps plus done), a write-back
//   and the output load. The divider sets the rate; one poll is in flight
//   at a time, and a new poll is taken only after the last result beat.
//   A poll for an out-of-range button skips straight to the output load.
//   The result sits in an output register; s_axis_tready rises again once
//   that register is free, so a stalled receiver holds the block.
// Reset:
//   Per-button state is held in a small memory with a valid bit per entry;
//   reset clears the valid bits, so an invalid entry reads as all zero.
//   Registers return to 300 / 1000 / 5000 / 0.
// ----------------------------------------------------------------------------
module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int NUM_BUTTONS  = 3,
  parameter int MIN_PRESS_MS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] button_index, [2] button_down, [34:3] now_ms, [66:35] held_ms
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] event_valid, [2:1] event_button, [3] event_released,
  // [6:4] event_kind, [16:7] hold_progress, [17] redraw_needed
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [15:0] win_q, long_q, vlong_q;
  logic [14:0] masks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= 16'd300;
      long_q  <= 16'd1000;
      vlong_q <= 16'd5000;
      masks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW: win_q   <= cfg_data_i;
        REG_LONG:   long_q  <= cfg_data_i;
        REG_VLONG:  vlong_q <= cfg_data_i;
        REG_MASKS:  masks_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // latched poll
  logic [1:0]  bidx_q;
  logic        down_q;
  logic [31:0] now_q, held_q;
  logic        inr;
  logic [BW-1:0] addr;
  assign addr = BW'(bidx_q);

  // state memory
  btn_state_t mem_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld_q;
  btn_state_t rd_q, cur, nxt;
  logic        rdv_q;
  logic        we;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= nxt;
    rd_q <= mem_q[addr];
  end

  fsm_e st_q, st_d;
  div_req_t dreq;
  div_rsp_t drsp;

  bpc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // mask of this button
  logic [4:0] m;
  always_comb begin
    m = '0;
    for (int i = 0; i < 3; i++)
      if (int'(bidx_q) == i) m = masks_q[5*i +: 5];
  end

  assign cur = rdv_q ? rd_q : '0;

  // progress setup
  logic [31:0] mint, d, e;
  logic [16:0] s;
  logic        above, low_part, sat;
  always_comb begin
    // floor(long / 5) by reciprocal multiply, exact for 16-bit operands
    mint = 32'(MIN_PRESS_MS) + (({16'd0, long_q} * 32'd52429) >> 18);
    above = held_q > mint;
    d = held_q - mint;
    low_part = (d <= {16'd0, long_q}) && (long_q != 16'd0);
    sat = vlong_q <= long_q;
    e = d - {16'd0, long_q};
    s = {1'b0, vlong_q} - {1'b0, long_q};
    dreq.start = (st_q == ST_READ);
    dreq.num = low_part ? {8'd0, d, 8'd0} : {8'd0, e, 8'd0};
    dreq.den = low_part ? {16'd0, long_q} : {15'd0, s};
  end

  logic [9:0] prog;
  always_comb begin
    if (low_part) prog = 10'(drsp.quo);
    else if (sat || drsp.quo >= 48'd256) prog = 10'd512;
    else prog = 10'd256 + 10'(drsp.quo);
  end

  function automatic logic kb(logic [4:0] mk, logic [2:0] k);
    return (k <= K_DOUBLE) ? mk[k] : 1'b0;
  endfunction

  // classification and update
  logic ev, rel, redraw_q, redraw_set;
  logic [2:0] kind, g, cls;
  logic [31:0] dt, wgap;
  always_comb begin
    nxt = cur;
    ev = 1'b0; rel = 1'b0; kind = K_START;
    dt = now_q - cur.start;
    if (dt >= 32'(MIN_PRESS_MS) && dt < {16'd0, long_q}) g = K_SHORT;
    else if (dt >= {16'd0, long_q} && dt < {16'd0, vlong_q}) g = K_LONG;
    else if (dt >= {16'd0, vlong_q}) g = K_VLONG;
    else g = K_START;
    cls = cur.cls;
    if (down_q) begin
      if (!cur.active) begin
        nxt.active = 1'b1; nxt.start = now_q; nxt.cls = K_START;
        if (m[K_START]) ev = 1'b1;
      end else if (g != cur.cls) begin
        nxt.cls = g;
        if (kb(m, g)) begin ev = 1'b1; kind = g; end
      end
    end else if (cur.active) begin
      if (m[K_DOUBLE] && cls == K_SHORT) begin
        if (cur.win_open && (now_q - cur.win_start) < {16'd0, win_q}) begin
          cls = K_DOUBLE; nxt.win_open = 1'b0; nxt.win_start = '0;
        end else begin
          cls = K_START; nxt.win_open = 1'b1; nxt.win_start = now_q;
        end
      end else begin
        nxt.win_open = 1'b0; nxt.win_start = '0;
      end
      if (m[K_LONG] && !m[K_VLONG] && cls == K_VLONG) cls = K_LONG;
      if (cls != K_START && kb(m, cls)) begin ev = 1'b1; rel = 1'b1; kind = cls; end
      nxt.active = 1'b0; nxt.start = '0; nxt.cls = K_START;
    end
    wgap = now_q - nxt.win_start;
    if (!down_q && m[K_SHORT] && nxt.win_open && wgap >= {16'd0, win_q}) begin
      nxt.win_open = 1'b0; nxt.win_start = '0;
      ev = 1'b1; rel = 1'b1; kind = K_SHORT;
    end
    redraw_set = 1'b0;
    if (above) begin
      if (prog != cur.level) begin
        nxt.level = prog;
        if (m[K_LONG] || m[K_VLONG]) redraw_set = 1'b1;
      end
    end else if (cur.level != 10'd0) begin
      nxt.level = '0; redraw_set = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (s_axis_tvalid && s_axis_tready) st_d = inr ? ST_READ : ST_OUT;
      ST_READ:  st_d = ST_DIV;
      ST_DIV:   if (drsp.done) st_d = ST_WRITE;
      ST_WRITE: st_d = ST_OUT;
      ST_OUT:   if (!m_axis_tvalid || m_axis_tready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  assign we = (st_q == ST_WRITE);
  assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;

  logic [23:0] res_q;
  logic        ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; vld_q <= '0; rdv_q <= 1'b0; redraw_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_READ) rdv_q <= vld_q[addr];
      if (we) begin
        vld_q[addr] <= 1'b1;
        if (redraw_set) redraw_q <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (st_q == ST_OUT && st_d == ST_IDLE) ov_q <= 1'b1;
    end
  end

  always_comb inr = int'(s_axis_tdata[1:0]) < NUM_BUTTONS;

  logic        ev_q, rel_q;
  logic [2:0]  kind_q;
  logic [9:0]  lvl_q;
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      bidx_q <= s_axis_tdata[1:0];
      down_q <= s_axis_tdata[2];
      now_q  <= s_axis_tdata[34:3];
      held_q <= s_axis_tdata[66:35];
      ev_q <= 1'b0; rel_q <= 1'b0; kind_q <= K_START; lvl_q <= '0;
    end
    if (we) begin
      ev_q <= ev; rel_q <= rel; kind_q <= kind; lvl_q <= nxt.level;
    end
    if (st_q == ST_OUT && st_d == ST_IDLE)
      res_q <= (int'(bidx_q) < NUM_BUTTONS)
        ? {6'd0, (redraw_q | (we & redraw_set)), lvl_q, kind_q, rel_q, bidx_q, ev_q}
        : {6'd0, 18'd0};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = res_q;

endmodule

@@ design/bpc_checker.sv @@
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the button press classifier.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second poll accepted while one is in flight");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:3] == 4'd0)
    else $error("kind or release set without an event");

  a_redraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[17] |=>
      !m_axis_tvalid || m_axis_tdata[17] || m_axis_tdata[2:1] == 2'd3)
    else $error("redraw flag dropped");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
